@@ rtl/aes_pkg.sv @@
// shared types, s-box and round helpers for the aes-128 encryption pipeline
`default_nettype none
package aes_pkg;

    localparam int unsigned HalfW  = 64;
    localparam int unsigned BlockW = 128;
    localparam int unsigned NRounds = 10;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [HalfW-1:0] plain_high;
        logic [HalfW-1:0] plain_low;
    } t_in;

    typedef struct packed {
        logic [HalfW-1:0] cipher_high;
        logic [HalfW-1:0] cipher_low;
    } t_out;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] RCON [NRounds] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
    };

    // byte i of a block sits at bits 127-8i .. 120-8i
    function automatic logic [7:0] get_byte(input logic [BlockW-1:0] b, input int i);
        get_byte = b[BlockW-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BlockW-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        sub_shift = t;
    endfunction

    function automatic logic [BlockW-1:0] mix(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            t[BlockW-1-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[BlockW-1-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[BlockW-1-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[BlockW-1-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        mix = t;
    endfunction

    function automatic logic [BlockW-1:0] next_key(input logic [BlockW-1:0] k,
                                                   input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_key = {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

@@ rtl/aes128_encrypt.sv @@
// aes-128 encryption top level: key registers, key schedule and round pipeline
//
// channel   direction  handshake              payload
// config    in         i_cfg_we               i_cfg_idx, i_cfg_data
// plain     in         start & !busy          i_plain (t_in)
// cipher    out        o_done strobe          o_cipher (t_out)
//
// one block enters per cycle; busy stays low
// registered stages: one register for the initial key add, one per round
// after a key write the key schedule settles through round keys r_rk[0] to r_rk[10] in order
// synchronous active-low reset clears valid bits and key registers
// results cannot be stalled
`default_nettype none
module aes128_encrypt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [aes_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [aes_pkg::HalfW-1:0]     i_cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire aes_pkg::t_in                  i_plain,
    output logic                               o_done,
    output aes_pkg::t_out                      o_cipher
);
    logic [aes_pkg::HalfW-1:0] r_key_high;
    logic [aes_pkg::HalfW-1:0] r_key_low;
    logic [aes_pkg::NRounds:0][aes_pkg::BlockW-1:0] w_rk;
    logic [aes_pkg::NRounds:0] w_valid;
    logic [aes_pkg::NRounds:0][aes_pkg::BlockW-1:0] w_state;
    logic r_v0;
    logic [aes_pkg::BlockW-1:0] r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_v0       <= 1'b0;
        end else begin
            r_v0 <= start;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aes_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    aes_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_s0 <= {i_plain.plain_high, i_plain.plain_low} ^ w_rk[0];
    end

    aes_keysched u_keys (
        .i_clk (i_clk),
        .i_key ({r_key_high, r_key_low}),
        .o_rk  (w_rk)
    );

    assign w_valid[0] = r_v0;
    assign w_state[0] = r_s0;

    // stage r+1 consumes round key r+1; stage 0 add uses key 0
    for (genvar g = 1; g <= aes_pkg::NRounds; g++) begin : g_round
        aes_round #(.LastRound(g == aes_pkg::NRounds)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g-1]),
            .i_state (w_state[g-1]),
            .i_rk    (w_rk[g]),
            .o_valid (w_valid[g]),
            .o_state (w_state[g])
        );
    end

    assign busy     = 1'b0;
    assign o_done   = w_valid[aes_pkg::NRounds];
    assign o_cipher = aes_pkg::t_out'(w_state[aes_pkg::NRounds]);

    a_first_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> r_v0) else $error("accepted block lost at entry");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] |-> ##10 o_done) else $error("block did not leave after ten rounds");
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_valid[aes_pkg::NRounds-1])) else $error("result without a block");
endmodule
`default_nettype wire

@@ rtl/aes_keysched.sv @@
// round key schedule, registered once per round key from the key registers
`default_nettype none
module aes_keysched (
    input  wire logic                          i_clk,
    input  wire logic [aes_pkg::BlockW-1:0]    i_key,
    output logic [aes_pkg::NRounds:0][aes_pkg::BlockW-1:0] o_rk
);
    // user keeps key changes while idle (unenforced), so chain settles before use
    logic [aes_pkg::NRounds:0][aes_pkg::BlockW-1:0] r_rk;

    always_ff @(posedge i_clk) begin
        r_rk[0] <= i_key;
        for (int r = 0; r < aes_pkg::NRounds; r++) begin
            r_rk[r+1] <= aes_pkg::next_key(r_rk[r], aes_pkg::RCON[r]);
        end
    end

    assign o_rk = r_rk;
endmodule
`default_nettype wire

@@ rtl/aes_round.sv @@
// one registered cipher round: subbytes, shiftrows, optional mixcolumns, addroundkey
`default_nettype none
module aes_round #(
    parameter bit LastRound = 1'b0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [aes_pkg::BlockW-1:0] i_state,
    input  wire logic [aes_pkg::BlockW-1:0] i_rk,
    output logic                            o_valid,
    output logic [aes_pkg::BlockW-1:0]      o_state
);
    logic                       r_valid;
    logic [aes_pkg::BlockW-1:0] r_state;
    logic [aes_pkg::BlockW-1:0] n_state;
    logic [aes_pkg::BlockW-1:0] w_ss;

    always_comb begin
        w_ss = aes_pkg::sub_shift(i_state);
        if (LastRound) begin
            n_state = w_ss ^ i_rk;
        end else begin
            n_state = aes_pkg::mix(w_ss) ^ i_rk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_state <= n_state;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
endmodule
`default_nettype wire
